>>> rtl/cfubs_pkg.sv
// Shared types and constants for the cube face rectangle and bounds scanner.
// Used by the front stage, the queue, the back stage and the top level.
`default_nettype none

package cfubs_pkg;

    localparam logic [2:0] FACE_WEST  = 3'd0;
    localparam logic [2:0] FACE_EAST  = 3'd1;
    localparam logic [2:0] FACE_DOWN  = 3'd2;
    localparam logic [2:0] FACE_UP    = 3'd3;
    localparam logic [2:0] FACE_NORTH = 3'd4;
    localparam logic [2:0] FACE_SOUTH = 3'd5;

    localparam logic [1:0] MODE_ABSENT   = 2'd0;
    localparam logic [1:0] MODE_FACE     = 2'd1;
    localparam logic [1:0] MODE_BOX      = 2'd2;
    localparam logic [1:0] MODE_BOX_ZERO = 2'd3;

    // Classification of a word as it leaves the front stage.
    localparam logic [1:0] KIND_ABSENT  = 2'd0;
    localparam logic [1:0] KIND_BAD_ROT = 2'd1;
    localparam logic [1:0] KIND_FACE    = 2'd2;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_ROTATION  = 2'd1;
    localparam logic [1:0] ERR_COUNT     = 2'd2;
    localparam logic [1:0] ERR_FAILED    = 2'd3;

    // Rotation reduction: offset by a multiple of 360 to make it positive, then
    // divide by 360 with a reciprocal multiply and a one-step correction.
    localparam int ROT_OFFSET = 36000;
    localparam int ROT_MOD    = 360;
    localparam int ROT_QUART  = 90;
    localparam int ROT_RECIP  = 11651;
    localparam int ROT_SHIFT  = 22;

    localparam logic [31:0] COUNT_FULL = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              start;
        logic [1:0]        kind;
        logic [1:0]        qt;
        logic signed [31:0] u0;
        logic signed [31:0] v0;
        logic signed [31:0] u1;
        logic signed [31:0] v1;
    } face_entry_t;

    typedef struct packed {
        logic signed [31:0] u0;
        logic signed [31:0] v0;
        logic signed [31:0] u1;
        logic signed [31:0] v1;
        logic [1:0]         qt;
        logic               present;
        logic [1:0]         err;
        logic signed [31:0] min_u;
        logic signed [31:0] min_v;
        logic signed [31:0] max_u;
        logic signed [31:0] max_v;
        logic [31:0]        count;
    } scan_result_t;

endpackage

`default_nettype wire

>>> rtl/cfubs_front.sv
// Front stage: takes input words, reduces rotation and sizes, then resolves
// the face rectangle and classifies the word. Depends on cfubs_pkg.
`default_nettype none

module cfubs_front #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 start_scan,
    input  wire logic [2:0]           face_select,
    input  wire logic [1:0]           cube_mode,
    input  wire logic signed [23:0]   size_x,
    input  wire logic signed [23:0]   size_y,
    input  wire logic signed [23:0]   size_z,
    input  wire logic                 mode_flag,
    input  wire logic signed [23:0]   anchor_u,
    input  wire logic signed [23:0]   anchor_v,
    input  wire logic signed [23:0]   face_span_u,
    input  wire logic signed [23:0]   face_span_v,
    input  wire logic signed [15:0]   rotation_deg,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output cfubs_pkg::face_entry_t    out_entry
);

    localparam logic [23:0] FRAC_MASK = 24'((64'd1 << FRAC_BITS) - 64'd1);

    logic               valid_reg, valid_next;
    logic               start_reg;
    logic [2:0]         face_reg;
    logic [1:0]         mode_reg;
    logic               flag_reg;
    logic signed [23:0] ou_reg, ov_reg, spu_reg, spv_reg;
    logic [23:0]        ax_reg, ay_reg, az_reg;
    logic [16:0]        rot_x_reg;
    logic [8:0]         rot_q_reg;

    logic signed [24:0] sx_e, sy_e, sz_e;
    logic [23:0]        ax_c, ay_c, az_c;
    logic signed [17:0] rot_e;
    logic [16:0]        rot_x_c;
    logic [30:0]        rot_prod;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_comb begin
        sx_e = 25'(size_x);
        sy_e = 25'(size_y);
        sz_e = 25'(size_z);
        ax_c = sx_e[24] ? 24'(-sx_e) : sx_e[23:0];
        ay_c = sy_e[24] ? 24'(-sy_e) : sy_e[23:0];
        az_c = sz_e[24] ? 24'(-sz_e) : sz_e[23:0];
        rot_e    = 18'(rotation_deg) + 18'(cfubs_pkg::ROT_OFFSET);
        rot_x_c  = rot_e[16:0];
        rot_prod = 31'(rot_x_c) * 31'(cfubs_pkg::ROT_RECIP);
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            start_reg <= start_scan;
            face_reg  <= face_select;
            mode_reg  <= cube_mode;
            flag_reg  <= mode_flag;
            ou_reg    <= anchor_u;
            ov_reg    <= anchor_v;
            spu_reg   <= face_span_u;
            spv_reg   <= face_span_v;
            ax_reg    <= ax_c;
            ay_reg    <= ay_c;
            az_reg    <= az_c;
            rot_x_reg <= rot_x_c;
            rot_q_reg <= rot_prod[cfubs_pkg::ROT_SHIFT +: 9];
        end
    end

    // Second half: rotation remainder, corner arithmetic and classification.
    logic [18:0]        q360;
    logic signed [18:0] rem_raw;
    logic [8:0]         rot_r;
    logic [1:0]         qt_c;
    logic [8:0]         rot_rem;
    logic               bad_rot;

    logic signed [31:0] aw, ah, ad, fw, fh, fd, ou32, ov32;
    logic signed [31:0] du, dv, pu0, pv0, pu1, pv1;
    logic signed [31:0] bu, bv, su, sv, bou, bov, ba, bb, bv0, bv1;
    logic [2:0]         bface;

    always_comb begin
        q360    = 19'(rot_q_reg) * 19'(cfubs_pkg::ROT_MOD);
        rem_raw = signed'(19'(rot_x_reg)) - signed'(q360);
        if (rem_raw < 0) begin
            rot_r = 9'(rem_raw + 19'sd360);
        end else if (rem_raw >= 19'sd360) begin
            rot_r = 9'(rem_raw - 19'sd360);
        end else begin
            rot_r = rem_raw[8:0];
        end
        if (rot_r >= 9'd270) begin
            qt_c = 2'd3;
        end else if (rot_r >= 9'd180) begin
            qt_c = 2'd2;
        end else if (rot_r >= 9'(cfubs_pkg::ROT_QUART)) begin
            qt_c = 2'd1;
        end else begin
            qt_c = 2'd0;
        end
        rot_rem = rot_r - 9'(qt_c) * 9'(cfubs_pkg::ROT_QUART);
        bad_rot = rot_rem != 9'd0;
    end

    always_comb begin
        aw   = signed'(32'(ax_reg));
        ah   = signed'(32'(ay_reg));
        ad   = signed'(32'(az_reg));
        fw   = signed'(32'(ax_reg & ~FRAC_MASK));
        fh   = signed'(32'(ay_reg & ~FRAC_MASK));
        fd   = signed'(32'(az_reg & ~FRAC_MASK));
        ou32 = 32'(ou_reg);
        ov32 = 32'(ov_reg);

        // Per-face rectangle.
        if (face_reg == cfubs_pkg::FACE_WEST || face_reg == cfubs_pkg::FACE_EAST) begin
            du = ad;
            dv = ah;
        end else if (face_reg == cfubs_pkg::FACE_DOWN || face_reg == cfubs_pkg::FACE_UP) begin
            du = aw;
            dv = ad;
        end else begin
            du = aw;
            dv = ah;
        end
        pu0 = ou32;
        pv0 = ov32;
        pu1 = ou32 + (flag_reg ? 32'(spu_reg) : du);
        pv1 = ov32 + (flag_reg ? 32'(spv_reg) : dv);

        // Box layout; mirroring exchanges east and west.
        bface = face_reg;
        if (flag_reg && face_reg == cfubs_pkg::FACE_WEST) begin
            bface = cfubs_pkg::FACE_EAST;
        end else if (flag_reg && face_reg == cfubs_pkg::FACE_EAST) begin
            bface = cfubs_pkg::FACE_WEST;
        end
        case (bface)
            cfubs_pkg::FACE_WEST: begin
                bu = '0;        bv = fd; su = fd; sv = fh;
            end
            cfubs_pkg::FACE_EAST: begin
                bu = fd + fw;   bv = fd; su = fd; sv = fh;
            end
            cfubs_pkg::FACE_DOWN: begin
                bu = fd + fw;   bv = '0; su = fw; sv = fd;
            end
            cfubs_pkg::FACE_UP: begin
                bu = fd;        bv = fd; su = fw; sv = -fd;
            end
            cfubs_pkg::FACE_NORTH: begin
                bu = fd;        bv = fd; su = fw; sv = fh;
            end
            default: begin
                bu = (fd <<< 1) + fw; bv = fd; su = fw; sv = fh;
            end
        endcase
        bou = (mode_reg == cfubs_pkg::MODE_BOX_ZERO) ? '0 : ou32;
        bov = (mode_reg == cfubs_pkg::MODE_BOX_ZERO) ? '0 : ov32;
        // A mirrored face simply exchanges its two u corners.
        ba  = bou + bu;
        bb  = ba + su;
        bv0 = bov + bv;
        bv1 = bv0 + sv;

        out_entry.start = start_reg;
        out_entry.qt    = 2'd0;
        if (face_reg > cfubs_pkg::FACE_SOUTH || mode_reg == cfubs_pkg::MODE_ABSENT) begin
            out_entry.kind = cfubs_pkg::KIND_ABSENT;
            out_entry.u0   = pu0;
            out_entry.v0   = pv0;
            out_entry.u1   = pu1;
            out_entry.v1   = pv1;
        end else if (mode_reg == cfubs_pkg::MODE_FACE) begin
            out_entry.kind = bad_rot ? cfubs_pkg::KIND_BAD_ROT : cfubs_pkg::KIND_FACE;
            out_entry.qt   = qt_c;
            if (face_reg == cfubs_pkg::FACE_DOWN || face_reg == cfubs_pkg::FACE_UP) begin
                out_entry.u0 = pu1;
                out_entry.v0 = pv1;
                out_entry.u1 = pu0;
                out_entry.v1 = pv0;
            end else begin
                out_entry.u0 = pu0;
                out_entry.v0 = pv0;
                out_entry.u1 = pu1;
                out_entry.v1 = pv1;
            end
        end else begin
            out_entry.kind = cfubs_pkg::KIND_FACE;
            out_entry.u0   = flag_reg ? bb : ba;
            out_entry.u1   = flag_reg ? ba : bb;
            out_entry.v0   = bv0;
            out_entry.v1   = bv1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cfubs_queue.sv
// Short queue of classified face words between the front and back stages.
// Depends on cfubs_pkg for the entry type.
`default_nettype none

module cfubs_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  wr_valid,
    output logic                       wr_ready,
    input  wire cfubs_pkg::face_entry_t wr_entry,
    output logic                       rd_valid,
    input  wire logic                  rd_ready,
    output cfubs_pkg::face_entry_t     rd_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    cfubs_pkg::face_entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = count_reg != CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cfubs_back.sv
// Back stage: applies scan state (bounds, face count, sticky error) to each
// queued face word and holds the result in the output register. Uses cfubs_pkg.
`default_nettype none

module cfubs_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire cfubs_pkg::face_entry_t in_entry,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output cfubs_pkg::scan_result_t     out_result
);

    logic signed [31:0] low_u_reg, low_v_reg, high_u_reg, high_v_reg;
    logic signed [31:0] low_u_next, low_v_next, high_u_next, high_v_next;
    logic               started_reg, started_next;
    logic [31:0]        count_reg, count_next;
    logic               failed_reg, failed_next;
    logic               valid_reg, valid_next;
    cfubs_pkg::scan_result_t res_reg, res_next;

    logic signed [31:0] lu, lv, hu, hv, mnu, mxu, mnv, mxv;
    logic               st, fl, present;
    logic [31:0]        cnt;
    logic [1:0]         err;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = res_reg;

    always_comb begin
        // A new scan starts from the reset state before this word is applied.
        lu  = in_entry.start ? '0 : low_u_reg;
        lv  = in_entry.start ? '0 : low_v_reg;
        hu  = in_entry.start ? '0 : high_u_reg;
        hv  = in_entry.start ? '0 : high_v_reg;
        st  = in_entry.start ? 1'b0 : started_reg;
        cnt = in_entry.start ? '0 : count_reg;
        fl  = in_entry.start ? 1'b0 : failed_reg;

        err     = cfubs_pkg::ERR_OK;
        present = 1'b0;
        if (fl) begin
            err = cfubs_pkg::ERR_FAILED;
        end else if (in_entry.kind == cfubs_pkg::KIND_BAD_ROT) begin
            err = cfubs_pkg::ERR_ROTATION;
        end else if (in_entry.kind == cfubs_pkg::KIND_FACE) begin
            if (cnt == cfubs_pkg::COUNT_FULL) begin
                err = cfubs_pkg::ERR_COUNT;
            end else begin
                present = 1'b1;
            end
        end

        mnu = (in_entry.u0 < in_entry.u1) ? in_entry.u0 : in_entry.u1;
        mxu = (in_entry.u0 > in_entry.u1) ? in_entry.u0 : in_entry.u1;
        mnv = (in_entry.v0 < in_entry.v1) ? in_entry.v0 : in_entry.v1;
        mxv = (in_entry.v0 > in_entry.v1) ? in_entry.v0 : in_entry.v1;

        low_u_next   = lu;
        low_v_next   = lv;
        high_u_next  = hu;
        high_v_next  = hv;
        started_next = st;
        count_next   = cnt;
        failed_next  = fl || err == cfubs_pkg::ERR_ROTATION || err == cfubs_pkg::ERR_COUNT;
        if (present) begin
            low_u_next   = (!st || mnu < lu) ? mnu : lu;
            low_v_next   = (!st || mnv < lv) ? mnv : lv;
            high_u_next  = (!st || mxu > hu) ? mxu : hu;
            high_v_next  = (!st || mxv > hv) ? mxv : hv;
            started_next = 1'b1;
            count_next   = cnt + 32'd1;
        end

        res_next.u0      = present ? in_entry.u0 : '0;
        res_next.v0      = present ? in_entry.v0 : '0;
        res_next.u1      = present ? in_entry.u1 : '0;
        res_next.v1      = present ? in_entry.v1 : '0;
        res_next.qt      = present ? in_entry.qt : 2'd0;
        res_next.present = present;
        res_next.err     = err;
        res_next.min_u   = low_u_next;
        res_next.min_v   = low_v_next;
        res_next.max_u   = high_u_next;
        res_next.max_v   = high_v_next;
        res_next.count   = count_next;

        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_u_reg   <= '0;
            low_v_reg   <= '0;
            high_u_reg  <= '0;
            high_v_reg  <= '0;
            started_reg <= 1'b0;
            count_reg   <= '0;
            failed_reg  <= 1'b0;
            valid_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (in_valid && in_ready) begin
                low_u_reg   <= low_u_next;
                low_v_reg   <= low_v_next;
                high_u_reg  <= high_u_next;
                high_v_reg  <= high_v_next;
                started_reg <= started_next;
                count_reg   <= count_next;
                failed_reg  <= failed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cube_face_uv_bounds_scan_top.sv
// Cube face texture rectangle resolver with running bounds over a scan.
// On an empty pipe an input word passes through the front register and the queue into the back
// stage's output register; one word is accepted every cycle while the queue has room, and the back
// stage updates its scan state for each word it accepts. Reset (aresetn low, synchronous) empties the
// front register, the queue and the output register, and clears bounds, count and error.
// Depends on cfubs_pkg, cfubs_front, cfubs_queue and cfubs_back.
`default_nettype none

module cube_face_uv_bounds_scan_top #(
    parameter int FRAC_BITS   = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // size_x[23:0], size_y[47:24], size_z[71:48], anchor_u[95:72],
    // anchor_v[119:96], face_span_u[143:120], face_span_v[167:144],
    // rotation_deg[183:168]
    input  wire logic [183:0] s_tdata,
    // start_scan[0], face_select[3:1], cube_mode[5:4], mode_flag[6]
    input  wire logic [6:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // rect_u0[31:0], rect_v0[63:32], rect_u1[95:64], rect_v1[127:96],
    // rot_quadrant[129:128], min_u[161:130], min_v[193:162], max_u[225:194],
    // max_v[257:226], counted_total[289:258], zero padding[295:290]
    output logic [295:0]      m_tdata,
    // face_present[0], error_code[2:1]
    output logic [2:0]        m_tuser
);

    logic                    fr_valid, fr_ready;
    cfubs_pkg::face_entry_t  fr_entry;
    logic                    q_valid, q_ready;
    cfubs_pkg::face_entry_t  q_entry;
    cfubs_pkg::scan_result_t res;

    cfubs_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .start_scan   (s_tuser[0]),
        .face_select  (s_tuser[3:1]),
        .cube_mode    (s_tuser[5:4]),
        .size_x       (signed'(s_tdata[23:0])),
        .size_y       (signed'(s_tdata[47:24])),
        .size_z       (signed'(s_tdata[71:48])),
        .mode_flag    (s_tuser[6]),
        .anchor_u     (signed'(s_tdata[95:72])),
        .anchor_v     (signed'(s_tdata[119:96])),
        .face_span_u  (signed'(s_tdata[143:120])),
        .face_span_v  (signed'(s_tdata[167:144])),
        .rotation_deg (signed'(s_tdata[183:168])),
        .out_valid    (fr_valid),
        .out_ready    (fr_ready),
        .out_entry    (fr_entry)
    );

    cfubs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_entry (fr_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_entry (q_entry)
    );

    cfubs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_entry   (q_entry),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    assign m_tdata = {6'd0, res.count, res.max_v, res.max_u, res.min_v, res.min_u,
                      res.qt, res.v1, res.u1, res.v0, res.u0};
    assign m_tuser = {res.err, res.present};

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for cube_face_uv_bounds_scan_top: directed and random face words,
// checked against an in-bench predictor of rectangles, bounds, count and sticky errors.
// Depends on cfubs_pkg and the RTL top level only.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC       = 8;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 8;

    // One input word: tdata fields first, then the tuser fields, so that
    // {s_tdata, s_tuser} maps straight onto this struct.
    typedef struct packed {
        logic signed [15:0] rotation_deg;
        logic signed [23:0] span_v;
        logic signed [23:0] span_u;
        logic signed [23:0] anchor_v;
        logic signed [23:0] anchor_u;
        logic signed [23:0] size_z;
        logic signed [23:0] size_y;
        logic signed [23:0] size_x;
        logic               mode_flag;
        logic [1:0]         cube_mode;
        logic [2:0]         face_select;
        logic               start_scan;
    } face_item_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // size_x, size_y, size_z, anchor_u, anchor_v, face_span_u, face_span_v, rotation_deg
    logic [183:0] s_tdata;
    // start_scan, face_select, cube_mode, mode_flag
    logic [6:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // rect_u0, rect_v0, rect_u1, rect_v1, rot_quadrant, min_u, min_v, max_u, max_v,
    // counted_total, zero padding
    logic [295:0] m_tdata;
    // face_present, error_code
    logic [2:0]   m_tuser;

    cube_face_uv_bounds_scan_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Predictor state for the current scan.
    longint       bound_lo_u, bound_lo_v, bound_hi_u, bound_hi_v;
    bit           bounds_valid;
    logic [31:0]  counted_faces;
    bit           scan_dead;

    cfubs_pkg::scan_result_t expected_rects[$];

    int tx_idle_pct;
    int rx_stall_pct;
    int mismatches;
    int stall_cycles;
    int words_sent;
    int results_checked;
    int error_results;
    int counted_results;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void clear_scan();
        bound_lo_u = 0;
        bound_lo_v = 0;
        bound_hi_u = 0;
        bound_hi_v = 0;
        bounds_valid = 1'b0;
        counted_faces = '0;
        scan_dead = 1'b0;
    endfunction

    function automatic longint labs(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint lmin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    // Works out the result word for one accepted face word and advances the scan state.
    function automatic cfubs_pkg::scan_result_t resolve_face(face_item_t it);
        longint     sx, sy, sz, ou, ov, spu, spv;
        longint     w, h, d, du, dv, bu, bv, su, sv, tmp;
        longint     u0, v0, u1, v1;
        longint     frac_mask;
        int         rot;
        int         qt;
        logic [1:0] err;
        logic [2:0] f;
        bit         present;
        cfubs_pkg::scan_result_t r;

        sx = it.size_x;
        sy = it.size_y;
        sz = it.size_z;
        ou = it.anchor_u;
        ov = it.anchor_v;
        spu = it.span_u;
        spv = it.span_v;
        rot = it.rotation_deg;
        u0 = 0;
        v0 = 0;
        u1 = 0;
        v1 = 0;
        qt = 0;
        err = cfubs_pkg::ERR_OK;
        present = 1'b0;
        frac_mask = (longint'(1) << FRAC) - 1;

        if (it.start_scan)
            clear_scan();

        if (scan_dead) begin
            err = cfubs_pkg::ERR_FAILED;
        end else if (it.face_select > cfubs_pkg::FACE_SOUTH ||
                     it.cube_mode == cfubs_pkg::MODE_ABSENT) begin
            present = 1'b0;
        end else if (it.cube_mode == cfubs_pkg::MODE_FACE) begin
            if (rot % 90 != 0) begin
                err = cfubs_pkg::ERR_ROTATION;
            end else begin
                w = labs(sx);
                h = labs(sy);
                d = labs(sz);
                if (it.face_select == cfubs_pkg::FACE_WEST ||
                    it.face_select == cfubs_pkg::FACE_EAST) begin
                    du = d;
                    dv = h;
                end else if (it.face_select == cfubs_pkg::FACE_DOWN ||
                             it.face_select == cfubs_pkg::FACE_UP) begin
                    du = w;
                    dv = d;
                end else begin
                    du = w;
                    dv = h;
                end
                u0 = ou;
                v0 = ov;
                u1 = ou + (it.mode_flag ? spu : du);
                v1 = ov + (it.mode_flag ? spv : dv);
                // Up and down faces have both corners exchanged.
                if (it.face_select == cfubs_pkg::FACE_DOWN ||
                    it.face_select == cfubs_pkg::FACE_UP) begin
                    tmp = u0;
                    u0 = u1;
                    u1 = tmp;
                    tmp = v0;
                    v0 = v1;
                    v1 = tmp;
                end
                qt = (((rot % 360) + 360) % 360) / 90;
                present = 1'b1;
            end
        end else begin
            w = labs(sx) & ~frac_mask;
            h = labs(sy) & ~frac_mask;
            d = labs(sz) & ~frac_mask;
            f = it.face_select;
            if (it.mode_flag && f == cfubs_pkg::FACE_WEST)
                f = cfubs_pkg::FACE_EAST;
            else if (it.mode_flag && f == cfubs_pkg::FACE_EAST)
                f = cfubs_pkg::FACE_WEST;
            case (f)
                cfubs_pkg::FACE_WEST: begin
                    bu = 0;     bv = d; su = d; sv = h;
                end
                cfubs_pkg::FACE_EAST: begin
                    bu = d + w; bv = d; su = d; sv = h;
                end
                cfubs_pkg::FACE_DOWN: begin
                    bu = d + w; bv = 0; su = w; sv = d;
                end
                cfubs_pkg::FACE_UP: begin
                    bu = d;     bv = d; su = w; sv = -d;
                end
                cfubs_pkg::FACE_NORTH: begin
                    bu = d;     bv = d; su = w; sv = h;
                end
                default: begin
                    bu = 2 * d + w; bv = d; su = w; sv = h;
                end
            endcase
            if (it.mode_flag) begin
                bu = bu + su;
                su = -su;
            end
            if (it.cube_mode == cfubs_pkg::MODE_BOX_ZERO) begin
                ou = 0;
                ov = 0;
            end
            u0 = ou + bu;
            v0 = ov + bv;
            u1 = u0 + su;
            v1 = v0 + sv;
            present = 1'b1;
        end

        if (present && counted_faces == cfubs_pkg::COUNT_FULL) begin
            err = cfubs_pkg::ERR_COUNT;
            present = 1'b0;
        end
        if (err == cfubs_pkg::ERR_ROTATION || err == cfubs_pkg::ERR_COUNT)
            scan_dead = 1'b1;

        if (present) begin
            if (!bounds_valid) begin
                bound_lo_u = lmin(u0, u1);
                bound_hi_u = lmax(u0, u1);
                bound_lo_v = lmin(v0, v1);
                bound_hi_v = lmax(v0, v1);
                bounds_valid = 1'b1;
            end else begin
                bound_lo_u = lmin(bound_lo_u, lmin(u0, u1));
                bound_hi_u = lmax(bound_hi_u, lmax(u0, u1));
                bound_lo_v = lmin(bound_lo_v, lmin(v0, v1));
                bound_hi_v = lmax(bound_hi_v, lmax(v0, v1));
            end
            counted_faces = counted_faces + 32'd1;
        end else begin
            u0 = 0;
            v0 = 0;
            u1 = 0;
            v1 = 0;
            qt = 0;
        end

        r.u0 = u0[31:0];
        r.v0 = v0[31:0];
        r.u1 = u1[31:0];
        r.v1 = v1[31:0];
        r.qt = qt[1:0];
        r.present = present;
        r.err = err;
        r.min_u = bound_lo_u[31:0];
        r.min_v = bound_lo_v[31:0];
        r.max_u = bound_hi_u[31:0];
        r.max_v = bound_hi_v[31:0];
        r.count = counted_faces;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Input monitor with prediction, output checker, receiver stalls and the stall counter.
    always @(posedge aclk) begin
        cfubs_pkg::scan_result_t want;
        cfubs_pkg::scan_result_t got;
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
        if (!aresetn) begin
            clear_scan();
        end else begin
            if (m_tvalid && m_tready) begin
                got.u0 = m_tdata[31:0];
                got.v0 = m_tdata[63:32];
                got.u1 = m_tdata[95:64];
                got.v1 = m_tdata[127:96];
                got.qt = m_tdata[129:128];
                got.min_u = m_tdata[161:130];
                got.min_v = m_tdata[193:162];
                got.max_u = m_tdata[225:194];
                got.max_v = m_tdata[257:226];
                got.count = m_tdata[289:258];
                got.present = m_tuser[0];
                got.err = m_tuser[2:1];
                if (expected_rects.size() == 0) begin
                    $display("%0t ns: result word with none expected, tdata %0h tuser %0h",
                             $time, m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    want = expected_rects.pop_front();
                    check_field("rect_u0", want.u0, got.u0);
                    check_field("rect_v0", want.v0, got.v0);
                    check_field("rect_u1", want.u1, got.u1);
                    check_field("rect_v1", want.v1, got.v1);
                    check_field("rot_quadrant", 32'(want.qt), 32'(got.qt));
                    check_field("face_present", 32'(want.present), 32'(got.present));
                    check_field("error_code", 32'(want.err), 32'(got.err));
                    check_field("min_u", want.min_u, got.min_u);
                    check_field("min_v", want.min_v, got.min_v);
                    check_field("max_u", want.max_u, got.max_u);
                    check_field("max_v", want.max_v, got.max_v);
                    check_field("counted_total", want.count, got.count);
                    check_field("padding", 32'd0, 32'(m_tdata[295:290]));
                    results_checked++;
                    if (want.err != cfubs_pkg::ERR_OK)
                        error_results++;
                    if (want.present)
                        counted_results++;
                end
            end
            if (s_tvalid && s_tready) begin
                expected_rects.push_back(resolve_face({s_tdata, s_tuser}));
                words_sent++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else if (s_tvalid || expected_rects.size() != 0)
                stall_cycles++;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("Timed out after %0d cycles without a handshake", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Presents one face word after a random idle gap and returns once it is taken.
    task automatic send_face(face_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        {s_tdata, s_tuser} <= it;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // Withdraws the last word, then waits until every result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_rects.size() != 0)
            @(posedge aclk);
    endtask

    function automatic face_item_t make_face(bit start, logic [2:0] face, logic [1:0] mode,
                                             bit flag, int sx, int sy, int sz, int ou,
                                             int ov, int spu, int spv, int rot);
        face_item_t it;
        it.start_scan = start;
        it.face_select = face;
        it.cube_mode = mode;
        it.mode_flag = flag;
        it.size_x = 24'(sx);
        it.size_y = 24'(sy);
        it.size_z = 24'(sz);
        it.anchor_u = 24'(ou);
        it.anchor_v = 24'(ov);
        it.span_u = 24'(spu);
        it.span_v = 24'(spv);
        it.rotation_deg = 16'(rot);
        return it;
    endfunction

    function automatic int random_coord();
        if ($urandom_range(3) == 0)
            return int'($urandom_range(8191)) - 4096;
        return int'($urandom);
    endfunction

    // Mostly healthy scans: few bad rotations, occasional new scans and undefined faces.
    function automatic face_item_t random_face();
        face_item_t it;
        it.start_scan = ($urandom_range(15) == 0);
        if ($urandom_range(19) == 0)
            it.face_select = 3'(6 + $urandom_range(1));
        else
            it.face_select = 3'($urandom_range(5));
        it.cube_mode = 2'($urandom_range(3));
        it.mode_flag = 1'($urandom_range(1));
        it.size_x = 24'(random_coord());
        it.size_y = 24'(random_coord());
        it.size_z = 24'(random_coord());
        it.anchor_u = 24'(random_coord());
        it.anchor_v = 24'(random_coord());
        it.span_u = 24'(random_coord());
        it.span_v = 24'(random_coord());
        if ($urandom_range(19) == 0)
            it.rotation_deg = 16'($urandom);
        else
            it.rotation_deg = 16'((int'($urandom_range(728)) - 364) * 90);
        return it;
    endfunction

    task automatic test_per_face();
        send_face(make_face(1, cfubs_pkg::FACE_WEST, cfubs_pkg::MODE_FACE, 0,
                            8388607, -8388608, 300, 8388607, -8388608, 0, 0, 0));
        send_face(make_face(0, cfubs_pkg::FACE_EAST, cfubs_pkg::MODE_FACE, 1, 0, 0, 0,
                            -8388608, 8388607, 8388607, -8388608, 90));
        send_face(make_face(0, cfubs_pkg::FACE_DOWN, cfubs_pkg::MODE_FACE, 0,
                            1000, -2000, 3000, 256, -256, 0, 0, -90));
        send_face(make_face(0, cfubs_pkg::FACE_UP, cfubs_pkg::MODE_FACE, 1, 0, 0, 0,
                            100, 200, -8388608, 8388607, 270));
        send_face(make_face(0, cfubs_pkg::FACE_NORTH, cfubs_pkg::MODE_FACE, 0,
                            -8388608, -8388608, -8388608, 0, 0, 0, 0, 32670));
        send_face(make_face(0, cfubs_pkg::FACE_SOUTH, cfubs_pkg::MODE_FACE, 0,
                            8388607, 8388607, 8388607, -5000, 7000, 0, 0, -32760));
        // An absent face is not checked for its rotation.
        send_face(make_face(0, cfubs_pkg::FACE_WEST, cfubs_pkg::MODE_ABSENT, 1,
                            5, 6, 7, 8, 9, 10, 11, 45));
        // Undefined faces behave as absent, whatever the mode.
        send_face(make_face(0, 3'd6, cfubs_pkg::MODE_BOX, 0, 4096, 4096, 4096,
                            0, 0, 0, 0, 0));
        send_face(make_face(0, 3'd7, cfubs_pkg::MODE_FACE, 1, 4096, 4096, 4096,
                            0, 0, 0, 0, 1));
        wait_drained();
    endtask

    task automatic test_box_layout();
        for (int f = cfubs_pkg::FACE_WEST; f <= cfubs_pkg::FACE_SOUTH; f++)
            send_face(make_face(f == cfubs_pkg::FACE_WEST, 3'(f), cfubs_pkg::MODE_BOX, 0,
                                32'h1234, -32'h2345, 32'h0456, -777, 999, 0, 0, 45));
        // Mirroring exchanges east and west and flips u on every face.
        send_face(make_face(0, cfubs_pkg::FACE_WEST, cfubs_pkg::MODE_BOX, 1,
                            -8388608, 8388607, -8388608, 8388607, -8388608, 0, 0, 0));
        send_face(make_face(0, cfubs_pkg::FACE_EAST, cfubs_pkg::MODE_BOX, 1,
                            8388607, -8388608, 8388607, -8388608, 8388607, 0, 0, 0));
        send_face(make_face(0, cfubs_pkg::FACE_SOUTH, cfubs_pkg::MODE_BOX, 1,
                            513, 255, 1023, 10, 20, 0, 0, 0));
        send_face(make_face(0, cfubs_pkg::FACE_UP, cfubs_pkg::MODE_BOX_ZERO, 1,
                            2560, 1280, 768, 8388607, 8388607, 0, 0, 7));
        wait_drained();
    endtask

    task automatic test_sticky_error();
        send_face(make_face(1, cfubs_pkg::FACE_NORTH, cfubs_pkg::MODE_FACE, 0,
                            256, 256, 256, 0, 0, 0, 0, 32767));
        send_face(make_face(0, cfubs_pkg::FACE_DOWN, cfubs_pkg::MODE_BOX, 0,
                            256, 256, 256, 0, 0, 0, 0, 0));
        send_face(make_face(0, cfubs_pkg::FACE_WEST, cfubs_pkg::MODE_ABSENT, 0,
                            0, 0, 0, 0, 0, 0, 0, 0));
        send_face(make_face(1, cfubs_pkg::FACE_EAST, cfubs_pkg::MODE_FACE, 1,
                            0, 0, 0, 1, 2, 3, 4, -32768));
        // A new scan clears the failure even when its first face is absent.
        send_face(make_face(1, cfubs_pkg::FACE_SOUTH, cfubs_pkg::MODE_ABSENT, 0,
                            0, 0, 0, 0, 0, 0, 0, 0));
        send_face(make_face(1, cfubs_pkg::FACE_NORTH, cfubs_pkg::MODE_BOX, 0,
                            1024, 2048, 512, -100, 100, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_random_scan(int count, int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < count; i++)
            send_face(random_face());
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        mismatches = 0;
        stall_cycles = 0;
        words_sent = 0;
        results_checked = 0;
        error_results = 0;
        counted_results = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_per_face();
        test_box_layout();
        test_sticky_error();
        test_random_scan(256, 0, 0);
        test_random_scan(256, 47, 0);
        test_random_scan(256, 0, 47);
        test_random_scan(256, 30, 30);

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d face words and checked %0d result words under four pressure settings;",
                 words_sent, results_checked);
        $display("%0d results counted a face and %0d carried an error code.",
                 counted_results, error_results);
        if (mismatches == 0 && expected_rects.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     expected_rects.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/cfubs_pkg.sv
rtl/cfubs_front.sv
rtl/cfubs_queue.sv
rtl/cfubs_back.sv
rtl/cube_face_uv_bounds_scan_top.sv
dv/testbench.sv
